/* hw/rtl/lsbc_pkg.sv */
// ----------------------------------------------------------------------------
// lsbc_pkg: shared types and constants of the LRU sector buffer cache
// Request and result beats, buffer tags, update commands, sequencer states.
// ----------------------------------------------------------------------------
package lsbc_pkg;

  localparam int unsigned BUFFERS_PER_LIST = 2;
  localparam int unsigned NUM_LISTS        = 2;
  localparam int unsigned NUM_BUFS         = NUM_LISTS * BUFFERS_PER_LIST;
  localparam int unsigned ID_W             = $clog2(NUM_BUFS);
  localparam int unsigned POS_W            = (BUFFERS_PER_LIST > 1) ?
                                             $clog2(BUFFERS_PER_LIST) : 1;

  typedef logic [ID_W-1:0]  buf_id_t;
  typedef logic [POS_W-1:0] pos_t;

  // access kinds
  localparam logic [1:0] KIND_FAT  = 2'd0;
  localparam logic [1:0] KIND_ROOT = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // result actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_DONE  = 2'd2;

  // media status codes
  localparam logic [1:0] MS_SAME    = 2'd0;
  localparam logic [1:0] MS_MAYBE   = 2'd1;
  localparam logic [1:0] MS_CHANGED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FAT_OFFSET  = 2'd0;
  localparam logic [1:0] CFG_ROOT_OFFSET = 2'd1;
  localparam logic [1:0] CFG_DATA_OFFSET = 2'd2;
  localparam logic [1:0] CFG_FAT_LENGTH  = 2'd3;

  typedef struct packed {
    logic [4:0]  drive;
    logic [1:0]  access_kind;
    logic [31:0] record;
    logic        write_access;
    logic [1:0]  media_status;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] sector;
    logic [4:0]  target_drive;
    logic [1:0]  buffer_slot;
    logic        was_hit;
    logic        media_error;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [4:0]  drive;
    logic [1:0]  kind;
    logic [31:0] rec;
  } tag_t;

  // tag and list update command from the sequencer to the tag store
  typedef struct packed {
    logic        fill;
    logic        mark_dirty;
    logic        touch;
    logic        list;
    pos_t        vpos;
    buf_id_t     id;
    logic [4:0]  drive;
    logic [1:0]  kind;
    logic [31:0] rec;
  } upd_t;

  typedef enum logic [1:0] {
    ALU_VICTIM,
    ALU_MIRROR,
    ALU_FETCH
  } alu_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_WB_MAIN,
    ST_WB_MIRROR,
    ST_FETCH,
    ST_FINISH
  } state_e;

  // low two bits of a buffer id, zero-extended for small configurations
  function automatic logic [1:0] slot_of(input buf_id_t id);
    logic [ID_W+1:0] ext;
    ext = (ID_W + 2)'(id);
    return ext[1:0];
  endfunction

endpackage

/* hw/rtl/lsbc_alu.sv */
// ----------------------------------------------------------------------------
// lsbc_alu: shared sector adder
// One 32-bit add/subtract unit that forms every disk sector number in turn.
// ----------------------------------------------------------------------------
module lsbc_alu (
  input  lsbc_pkg::alu_sel_e sel_i,
  input  logic [31:0]        req_rec_i,
  input  logic [31:0]        req_off_i,
  input  logic [31:0]        vic_rec_i,
  input  logic [31:0]        vic_off_i,
  input  logic [31:0]        prev_sum_i,
  input  logic [15:0]        fat_len_i,
  output logic [31:0]        sum_o
);

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic        carry_in;

  always_comb begin
    op_a     = req_rec_i;
    op_b     = req_off_i;
    carry_in = 1'b0;
    case (sel_i)
      lsbc_pkg::ALU_VICTIM: begin
        op_a = vic_rec_i;
        op_b = vic_off_i;
      end
      lsbc_pkg::ALU_MIRROR: begin
        // subtract the FAT length: add its complement plus one
        op_a     = prev_sum_i;
        op_b     = ~{16'd0, fat_len_i};
        carry_in = 1'b1;
      end
      lsbc_pkg::ALU_FETCH: begin
        op_a = req_rec_i;
        op_b = req_off_i;
      end
      default: begin
        op_a = req_rec_i;
        op_b = req_off_i;
      end
    endcase
  end

  assign sum_o = op_a + op_b + {31'd0, carry_in};

endmodule

/* hw/rtl/lsbc_tags.sv */
// ----------------------------------------------------------------------------
// lsbc_tags: buffer tags and LRU lists
// Holds one tag per buffer and the use order of both lists; one read port.
// ----------------------------------------------------------------------------
module lsbc_tags (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_list_i,
  input  lsbc_pkg::pos_t    rd_pos_i,
  output lsbc_pkg::buf_id_t rd_id_o,
  output lsbc_pkg::tag_t    rd_tag_o,
  input  lsbc_pkg::upd_t    upd_i
);

  lsbc_pkg::tag_t    tag_q   [lsbc_pkg::NUM_BUFS];
  lsbc_pkg::buf_id_t order_q [lsbc_pkg::NUM_LISTS][lsbc_pkg::BUFFERS_PER_LIST];

  assign rd_id_o  = order_q[rd_list_i][rd_pos_i];
  assign rd_tag_o = tag_q[rd_id_o];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < lsbc_pkg::NUM_BUFS; b++) begin
        tag_q[b] <= '0;
      end
      for (int l = 0; l < lsbc_pkg::NUM_LISTS; l++) begin
        for (int i = 0; i < lsbc_pkg::BUFFERS_PER_LIST; i++) begin
          order_q[l][i] <= lsbc_pkg::ID_W'(l * lsbc_pkg::BUFFERS_PER_LIST + i);
        end
      end
    end else begin
      if (upd_i.fill) begin
        tag_q[upd_i.id] <= '{valid: 1'b1, dirty: 1'b0, drive: upd_i.drive,
                             kind: upd_i.kind, rec: upd_i.rec};
      end
      if (upd_i.mark_dirty) begin
        tag_q[upd_i.id].dirty <= 1'b1;
      end
      // move the used buffer to the front, shift the ones ahead of it back
      if (upd_i.touch) begin
        for (int i = 0; i < lsbc_pkg::BUFFERS_PER_LIST; i++) begin
          if (i == 0) begin
            order_q[upd_i.list][i] <= upd_i.id;
          end else if (lsbc_pkg::POS_W'(i) <= upd_i.vpos) begin
            order_q[upd_i.list][i] <= order_q[upd_i.list][i-1];
          end
        end
      end
    end
  end

endmodule

/* hw/rtl/lru_sector_buffer_cache_core.sv */
// ----------------------------------------------------------------------------
// lru_sector_buffer_cache_core: LRU write-back sector buffer cache controller
// Looks up record requests in two LRU lists and issues disk commands.
// ----------------------------------------------------------------------------
// Sequence: a request beat is accepted only in the idle state; the tag compare
//   walks one list position a cycle, then the single sector adder forms one
//   command a cycle without output stall, and the block returns to idle before
//   it takes the next request.
// Reset: all buffers invalid and clean, both lists in initial order,
//   configuration registers zero; no clearing pass.
module lru_sector_buffer_cache_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lsbc_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lsbc_pkg::rsp_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i
);

  // configuration registers
  logic [31:0] fat_off_q, root_off_q, data_off_q;
  logic [15:0] fat_len_q;

  // sequencer state and request context
  lsbc_pkg::state_e  state_q, state_d;
  lsbc_pkg::req_t    req_q;
  logic              list_q;
  lsbc_pkg::pos_t    pos_q;
  logic              hit_q;
  lsbc_pkg::pos_t    hit_pos_q;
  logic              inv_q;
  lsbc_pkg::pos_t    inv_pos_q;
  lsbc_pkg::buf_id_t id_q;
  lsbc_pkg::pos_t    vpos_q;
  lsbc_pkg::tag_t    vic_q;
  logic [31:0]       sum_q;

  // output register
  logic              out_valid_q;
  lsbc_pkg::rsp_t    out_q;

  // tag store read port and update command
  lsbc_pkg::pos_t    rd_pos;
  lsbc_pkg::buf_id_t rd_id;
  lsbc_pkg::tag_t    rd_tag;
  lsbc_pkg::upd_t    upd;

  lsbc_pkg::alu_sel_e alu_sel;
  logic [31:0]        alu_sum;
  logic [31:0]        req_off;
  logic [31:0]        vic_off;

  logic               out_free;
  logic               emit;
  lsbc_pkg::rsp_t     item;
  logic               match;
  lsbc_pkg::pos_t     vpos_c;
  logic [1:0]         in_kind;
  lsbc_pkg::req_t     in_req;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_off_q  <= '0;
      root_off_q <= '0;
      data_off_q <= '0;
      fat_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsbc_pkg::CFG_FAT_OFFSET:  fat_off_q  <= cfg_wdata_i;
        lsbc_pkg::CFG_ROOT_OFFSET: root_off_q <= cfg_wdata_i;
        lsbc_pkg::CFG_DATA_OFFSET: data_off_q <= cfg_wdata_i;
        lsbc_pkg::CFG_FAT_LENGTH:  fat_len_q  <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sector offsets of the request kind and of the victim kind; kinds are
  // stored normalized, so only FAT, root and data show up here.
  always_comb begin
    case (req_q.access_kind)
      lsbc_pkg::KIND_FAT:  req_off = fat_off_q;
      lsbc_pkg::KIND_ROOT: req_off = root_off_q;
      default:             req_off = data_off_q;
    endcase
    case (vic_q.kind)
      lsbc_pkg::KIND_FAT:  vic_off = fat_off_q;
      lsbc_pkg::KIND_ROOT: vic_off = root_off_q;
      default:             vic_off = data_off_q;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tag store and shared adder
  // ---------------------------------------------------------------------------
  // Pick the victim position: hit, else last invalid buffer met, else tail.
  assign vpos_c = hit_q ? hit_pos_q :
                  (inv_q ? inv_pos_q : lsbc_pkg::POS_W'(lsbc_pkg::BUFFERS_PER_LIST - 1));
  assign rd_pos = (state_q == lsbc_pkg::ST_SEARCH) ? pos_q : vpos_c;

  lsbc_tags u_tags (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_list_i (list_q),
    .rd_pos_i  (rd_pos),
    .rd_id_o   (rd_id),
    .rd_tag_o  (rd_tag),
    .upd_i     (upd)
  );

  lsbc_alu u_alu (
    .sel_i      (alu_sel),
    .req_rec_i  (req_q.record),
    .req_off_i  (req_off),
    .vic_rec_i  (vic_q.rec),
    .vic_off_i  (vic_off),
    .prev_sum_i (sum_q),
    .fat_len_i  (fat_len_q),
    .sum_o      (alu_sum)
  );

  assign match = rd_tag.valid && (rd_tag.drive == req_q.drive) &&
                 (rd_tag.kind == req_q.access_kind) && (rd_tag.rec == req_q.record);

  // The output register can take a beat when empty or draining this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    emit              = 1'b0;
    alu_sel           = lsbc_pkg::ALU_FETCH;
    item              = '0;
    item.target_drive = req_q.drive;
    item.buffer_slot  = lsbc_pkg::slot_of(id_q);
    item.was_hit      = hit_q;
    upd               = '0;
    upd.list          = list_q;
    upd.vpos          = vpos_q;
    upd.id            = id_q;
    upd.drive         = req_q.drive;
    upd.kind          = req_q.access_kind;
    upd.rec           = req_q.record;
    case (state_q)
      lsbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lsbc_pkg::ST_SEARCH;
        end
      end
      lsbc_pkg::ST_SEARCH: begin
        // one list position per cycle, stop at a hit or at the tail
        if (match || pos_q == lsbc_pkg::POS_W'(lsbc_pkg::BUFFERS_PER_LIST - 1)) begin
          state_d = lsbc_pkg::ST_DECIDE;
        end
      end
      lsbc_pkg::ST_DECIDE: begin
        if (hit_q && req_q.media_status == lsbc_pkg::MS_CHANGED) begin
          // abort: one error beat, leave tags and lists alone
          emit              = 1'b1;
          item.action       = lsbc_pkg::ACT_DONE;
          item.target_drive = rd_tag.drive;
          item.buffer_slot  = lsbc_pkg::slot_of(rd_id);
          item.media_error  = 1'b1;
          item.last         = 1'b1;
          if (out_free) begin
            state_d = lsbc_pkg::ST_IDLE;
          end
        end else if (hit_q && req_q.media_status != lsbc_pkg::MS_MAYBE) begin
          state_d = lsbc_pkg::ST_FINISH;
        end else if (rd_tag.valid && rd_tag.dirty) begin
          state_d = lsbc_pkg::ST_WB_MAIN;
        end else begin
          state_d = lsbc_pkg::ST_FETCH;
        end
      end
      lsbc_pkg::ST_WB_MAIN: begin
        alu_sel           = lsbc_pkg::ALU_VICTIM;
        emit              = 1'b1;
        item.action       = lsbc_pkg::ACT_WRITE;
        item.sector       = alu_sum;
        item.target_drive = vic_q.drive;
        if (out_free) begin
          state_d = (vic_q.kind == lsbc_pkg::KIND_FAT) ? lsbc_pkg::ST_WB_MIRROR :
                                                         lsbc_pkg::ST_FETCH;
        end
      end
      lsbc_pkg::ST_WB_MIRROR: begin
        // second FAT copy sits one FAT length below the first
        alu_sel           = lsbc_pkg::ALU_MIRROR;
        emit              = 1'b1;
        item.action       = lsbc_pkg::ACT_WRITE;
        item.sector       = alu_sum;
        item.target_drive = vic_q.drive;
        if (out_free) begin
          state_d = lsbc_pkg::ST_FETCH;
        end
      end
      lsbc_pkg::ST_FETCH: begin
        alu_sel     = lsbc_pkg::ALU_FETCH;
        emit        = 1'b1;
        item.action = lsbc_pkg::ACT_READ;
        item.sector = alu_sum;
        if (out_free) begin
          upd.fill = 1'b1;
          state_d  = lsbc_pkg::ST_FINISH;
        end
      end
      lsbc_pkg::ST_FINISH: begin
        emit        = 1'b1;
        item.action = lsbc_pkg::ACT_DONE;
        item.last   = 1'b1;
        if (out_free) begin
          upd.touch      = 1'b1;
          upd.mark_dirty = req_q.write_access;
          state_d        = lsbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Fold the unused access kind code onto data.
  assign in_kind = (in_data_i.access_kind == lsbc_pkg::KIND_FAT)  ? lsbc_pkg::KIND_FAT :
                   (in_data_i.access_kind == lsbc_pkg::KIND_ROOT) ? lsbc_pkg::KIND_ROOT :
                                                                    lsbc_pkg::KIND_DATA;

  always_comb begin
    in_req             = in_data_i;
    in_req.access_kind = in_kind;
  end

  // Request context and search bookkeeping
  always_ff @(posedge clk_i) begin
    case (state_q)
      lsbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_q  <= in_req;
          list_q <= (in_kind != lsbc_pkg::KIND_FAT);
          pos_q  <= '0;
          hit_q  <= 1'b0;
          inv_q  <= 1'b0;
        end
      end
      lsbc_pkg::ST_SEARCH: begin
        if (match) begin
          hit_q     <= 1'b1;
          hit_pos_q <= pos_q;
        end else begin
          if (!rd_tag.valid) begin
            inv_q     <= 1'b1;
            inv_pos_q <= pos_q;
          end
          pos_q <= pos_q + lsbc_pkg::POS_W'(1);
        end
      end
      lsbc_pkg::ST_DECIDE: begin
        id_q   <= rd_id;
        vpos_q <= vpos_c;
        vic_q  <= rd_tag;
      end
      lsbc_pkg::ST_WB_MAIN: begin
        if (out_free) begin
          sum_q <= alu_sum;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: hold a stalled beat, load the next one when free
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      out_q <= item;
    end
  end

  assign in_stall_o  = (state_q != lsbc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/lsbc_checker.sv */
// ----------------------------------------------------------------------------
// lsbc_checker: port-level checks of the sector buffer cache
// Watches the request, result and configuration ports over time.
// ----------------------------------------------------------------------------
module lsbc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input lsbc_pkg::rsp_t out_data_o,
  input logic           cfg_we_i
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // one request at a time: after an accepted request the input stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in progress");

  // only the done beat closes a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.action == lsbc_pkg::ACT_DONE)))
    else $error("last flag does not match done beat");

  // a media error only comes on a hit, as the closing beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.media_error |-> out_data_o.last && out_data_o.was_hit)
    else $error("media error on a non-final or missed beat");

  // the user must change registers only while the block is idle and drained; the block does not enforce it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o && !out_valid_o)
    else $error("configuration write while a request is in flight");

endmodule

bind lru_sector_buffer_cache_core lsbc_checker u_lsbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i)
);
